[hdl/ppa_pkg.sv]
// Package for the per-CPU page allocator.
// Holds parameter defaults, register indexes, status codes, controller states
// and the command and status bundles between the controller and the datapath.
package ppa_pkg;

    localparam int CPUS_DEF      = 8;
    localparam int NUM_PAGES_DEF = 32768;
    localparam int BATCH_DEF     = 64;
    localparam int PAGE_SIZE_DEF = 4096;

    localparam logic [31:0] RST_REGION_START = 32'h8000_0000;
    localparam logic [31:0] RST_REGION_STOP  = 32'h8800_0000;

    localparam logic CFG_REGION_START = 1'b0;
    localparam logic CFG_REGION_STOP  = 1'b1;

    localparam logic CMD_FREE  = 1'b0;
    localparam logic CMD_ALLOC = 1'b1;

    typedef enum logic [1:0] {
        ST_OK  = 2'd0,
        ST_BAD = 2'd1,
        ST_OOM = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FREE,
        S_ALLOC,
        S_POP,
        S_SCAN,
        S_WALK
    } t_state;

    typedef struct packed {
        logic load_in;
        logic rd_en;
        logic rd_from_data;
        logic sel_scan;
        logic start_walk;
        logic walk_step;
        logic scan_inc;
        logic free_commit;
        logic pop_commit;
        logic steal_commit;
        logic oom_commit;
    } t_cmd;

    typedef struct packed {
        logic req_nonempty;
        logic scan_hit;
        logic scan_last;
        logic walk_more;
        logic out_free;
    } t_stat;

endpackage

[hdl/ppa_ctrl.sv]
// Controller state machine of the per-CPU page allocator.
// Depends on ppa_pkg for the state type and the command and status bundles.
module ppa_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_cmd,
    output logic           o_in_stall,
    output ppa_pkg::t_cmd  o_cmd,
    input  ppa_pkg::t_stat i_stat
);
    import ppa_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state = (i_cmd == CMD_ALLOC) ? S_ALLOC : S_FREE;
                end
            end
            S_FREE: begin
                if (i_stat.out_free) begin
                    o_cmd.free_commit = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_ALLOC: begin
                if (i_stat.req_nonempty) begin
                    o_cmd.rd_en      = 1'b1;
                    o_cmd.start_walk = 1'b1;
                    n_state = S_POP;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_POP: begin
                if (i_stat.out_free) begin
                    o_cmd.pop_commit = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_SCAN: begin
                o_cmd.sel_scan = 1'b1;
                if (i_stat.scan_hit) begin
                    o_cmd.rd_en      = 1'b1;
                    o_cmd.start_walk = 1'b1;
                    n_state = S_WALK;
                end else if (i_stat.scan_last) begin
                    if (i_stat.out_free) begin
                        o_cmd.oom_commit = 1'b1;
                        n_state = S_IDLE;
                    end
                end else begin
                    o_cmd.scan_inc = 1'b1;
                end
            end
            S_WALK: begin
                o_cmd.sel_scan = 1'b1;
                if (i_stat.walk_more) begin
                    o_cmd.rd_en        = 1'b1;
                    o_cmd.rd_from_data = 1'b1;
                    o_cmd.walk_step    = 1'b1;
                end else if (i_stat.out_free) begin
                    o_cmd.steal_commit = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    a_accept_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=>
            (r_state == S_FREE && !$past(i_cmd)) || (r_state == S_ALLOC && $past(i_cmd)))
        else $error("accepted beat did not dispatch by command");

    a_hit_walks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && i_stat.scan_hit) |=> r_state == S_WALK)
        else $error("scan hit did not start a walk");

    a_walk_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK && !i_stat.walk_more && i_stat.out_free) |=> r_state == S_IDLE)
        else $error("finished walk did not return to idle");

endmodule

[hdl/ppa_dpath.sv]
// Datapath of the per-CPU page allocator: region registers, list heads,
// next-link memory, walk registers and the result register. Depends on ppa_pkg.
module ppa_dpath #(
    parameter int CPUS      = ppa_pkg::CPUS_DEF,
    parameter int NUM_PAGES = ppa_pkg::NUM_PAGES_DEF,
    parameter int BATCH     = ppa_pkg::BATCH_DEF,
    parameter int PAGE_SIZE = ppa_pkg::PAGE_SIZE_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_valid,
    input  logic           i_cfg_index,
    input  logic [31:0]    i_cfg_data,
    input  logic [2:0]     i_cpu,
    input  logic [31:0]    i_page_addr,
    input  logic           i_out_stall,
    output logic           o_out_valid,
    output logic [1:0]     o_status,
    output logic [31:0]    o_alloc_addr,
    input  ppa_pkg::t_cmd  i_cmd,
    output ppa_pkg::t_stat o_stat
);
    import ppa_pkg::*;

    localparam int CW = (CPUS > 1) ? $clog2(CPUS) : 1;
    localparam int PW = $clog2(NUM_PAGES);
    localparam int PB = $clog2(PAGE_SIZE);
    localparam int GW = $clog2(BATCH + 1);
    localparam logic [32:0] PMASK = 33'(PAGE_SIZE - 1);

    logic [31:0]    r_start;
    logic [31:0]    r_stop;
    logic [32:0]    r_base;
    logic [32:0]    n_base;
    logic [31:0]    r_pa;
    logic [CW-1:0]  r_req;
    logic [CW-1:0]  r_scan;
    logic [CW-1:0]  n_req;
    logic [4:0]     cpu_red;
    logic [PW-1:0]  r_head [CPUS];
    logic [CPUS-1:0] r_nonempty;
    logic [PW-1:0]  r_link [NUM_PAGES];
    logic [PW-1:0]  r_rdata;
    logic [PW-1:0]  r_tail;
    logic [PW-1:0]  r_h;
    logic [PW-1:0]  r_after_head;
    logic [GW-1:0]  r_got;
    logic           r_first;
    logic           r_out_valid;
    logic [1:0]     r_status;
    logic [31:0]    r_addr;
    logic [CW-1:0]  head_idx;
    logic [PW-1:0]  head_sel;
    logic [PW-1:0]  rd_addr;
    logic [32:0]    diff;
    logic [63:0]    off;
    logic [PW-1:0]  free_page;
    logic           free_ok;
    logic           we;
    logic [PW-1:0]  wr_addr;
    logic [PW-1:0]  wr_data;
    logic           load_out;
    logic [1:0]     n_status;
    logic [31:0]    n_addr;
    logic [PW-1:0]  addr_page;

    // CPU index reduced modulo CPUS by repeated subtraction.
    always_comb begin
        cpu_red = {2'b00, i_cpu};
        for (int k = 0; k < 4; k++) begin
            if (cpu_red >= 5'(CPUS)) begin
                cpu_red = cpu_red - 5'(CPUS);
            end
        end
        n_req = cpu_red[CW-1:0];
    end

    assign n_base = ({1'b0, i_cfg_data} + PMASK) & ~PMASK;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= RST_REGION_START;
            r_stop  <= RST_REGION_STOP;
            r_base  <= ({1'b0, RST_REGION_START} + PMASK) & ~PMASK;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_REGION_START: begin
                    r_start <= i_cfg_data;
                    r_base  <= n_base;
                end
                CFG_REGION_STOP: begin
                    r_stop <= i_cfg_data;
                end
                default: begin
                    r_stop <= r_stop;
                end
            endcase
        end
    end

    assign head_idx = i_cmd.sel_scan ? r_scan : r_req;
    assign head_sel = r_head[head_idx];
    assign rd_addr  = i_cmd.rd_from_data ? r_rdata : head_sel;

    assign diff      = {1'b0, r_pa} - r_base;
    assign off       = 64'(diff >> PB);
    assign free_page = off[PW-1:0];
    assign free_ok   = (r_pa[PB-1:0] == '0) && (r_pa >= r_start) && (r_pa < r_stop)
                       && (off < 64'(NUM_PAGES));

    assign we      = (i_cmd.free_commit && free_ok)
                     || (i_cmd.steal_commit && r_got > GW'(1));
    assign wr_addr = i_cmd.free_commit ? free_page : r_tail;
    assign wr_data = i_cmd.free_commit ? (r_nonempty[r_req] ? r_head[r_req] : free_page)
                                       : r_tail;

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_link[wr_addr] <= wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= r_link[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_pa  <= i_page_addr;
            r_req <= n_req;
        end
        if (i_cmd.start_walk) begin
            r_tail  <= head_sel;
            r_h     <= head_sel;
            r_got   <= GW'(1);
            r_first <= 1'b1;
        end else if (i_cmd.walk_step) begin
            r_tail  <= r_rdata;
            r_got   <= r_got + GW'(1);
            r_first <= 1'b0;
            if (r_first) begin
                r_after_head <= r_rdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan <= '0;
        end else if (i_cmd.load_in) begin
            r_scan <= '0;
        end else if (i_cmd.scan_inc) begin
            r_scan <= r_scan + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nonempty <= '0;
            for (int i = 0; i < CPUS; i++) begin
                r_head[i] <= '0;
            end
        end else begin
            if (i_cmd.free_commit && free_ok) begin
                r_head[r_req]     <= free_page;
                r_nonempty[r_req] <= 1'b1;
            end
            if (i_cmd.pop_commit) begin
                if (r_rdata == r_tail) begin
                    r_head[r_req]     <= '0;
                    r_nonempty[r_req] <= 1'b0;
                end else begin
                    r_head[r_req] <= r_rdata;
                end
            end
            if (i_cmd.steal_commit) begin
                if (r_rdata == r_tail) begin
                    r_head[r_scan]     <= '0;
                    r_nonempty[r_scan] <= 1'b0;
                end else begin
                    r_head[r_scan] <= r_rdata;
                end
                if (r_got > GW'(1)) begin
                    r_head[r_req]     <= r_after_head;
                    r_nonempty[r_req] <= 1'b1;
                end
            end
        end
    end

    assign o_stat.req_nonempty = r_nonempty[r_req];
    assign o_stat.scan_hit     = r_nonempty[r_scan] && (r_scan != r_req);
    assign o_stat.scan_last    = (r_scan == CW'(CPUS - 1));
    assign o_stat.walk_more    = (r_got < GW'(BATCH)) && (r_rdata != r_tail);
    assign o_stat.out_free     = !r_out_valid || !i_out_stall;

    assign load_out  = i_cmd.free_commit || i_cmd.pop_commit || i_cmd.steal_commit
                       || i_cmd.oom_commit;
    assign addr_page = i_cmd.pop_commit ? r_tail : r_h;

    always_comb begin
        n_status = ST_OK;
        n_addr   = '0;
        if (i_cmd.free_commit) begin
            n_status = free_ok ? ST_OK : ST_BAD;
        end else if (i_cmd.oom_commit) begin
            n_status = ST_OOM;
        end else begin
            n_addr = r_base[31:0] + (32'(addr_page) << PB);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (load_out) begin
            r_status <= n_status;
            r_addr   <= n_addr;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_alloc_addr = r_addr;

    a_one_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({i_cmd.free_commit, i_cmd.pop_commit, i_cmd.steal_commit,
                  i_cmd.oom_commit}))
        else $error("more than one commit in a cycle");

    a_commit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |=> r_out_valid)
        else $error("committed result not held in the output register");

    a_walk_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.walk_step |=> r_got <= GW'(BATCH))
        else $error("steal walked past the batch limit");

endmodule

[hdl/per_cpu_page_allocator.sv]
// Top level of the per-CPU page allocator.
// Instantiates ppa_ctrl and ppa_dpath; depends on ppa_pkg.
//
//   Channel  Handshake                   Beat contents
//   -------  --------------------------  ------------------------------
//   input    i_in_valid / o_in_stall     i_cmd, i_cpu, i_page_addr
//   output   o_out_valid / i_out_stall   o_status, o_alloc_addr
//   config   i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
// A free commits from S_FREE; a local allocate passes S_ALLOC and S_POP, which
// uses the registered read of the next-link memory. A steal scans the other
// CPUs in S_SCAN and on a hit walks at most BATCH - 1 links in S_WALK, else it
// ends in out of memory. Each commit also waits while a stalled beat holds the
// output register. One beat is in work at a time; the next is accepted while a
// result waits there. Reset empties every list; no clearing pass is needed.
module per_cpu_page_allocator #(
    parameter int CPUS      = ppa_pkg::CPUS_DEF,
    parameter int NUM_PAGES = ppa_pkg::NUM_PAGES_DEF,
    parameter int BATCH     = ppa_pkg::BATCH_DEF,
    parameter int PAGE_SIZE = ppa_pkg::PAGE_SIZE_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_cmd,
    input  logic [2:0]  i_cpu,
    input  logic [31:0] i_page_addr,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [31:0] o_alloc_addr,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import ppa_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    ppa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_cmd      (i_cmd),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd),
        .i_stat     (stat)
    );

    ppa_dpath #(
        .CPUS      (CPUS),
        .NUM_PAGES (NUM_PAGES),
        .BATCH     (BATCH),
        .PAGE_SIZE (PAGE_SIZE)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid && o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_cpu        (i_cpu),
        .i_page_addr  (i_page_addr),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_status     (o_status),
        .o_alloc_addr (o_alloc_addr),
        .i_cmd        (cmd),
        .o_stat       (stat)
    );

endmodule
